### hw/rtl/sdfps_pkg.sv
// Package for the signed-distance point splatter.
// Holds the shared constants, the sequencer state type and the default sizes.
// No dependencies.
package sdfps_pkg;

  // Default sizes handed to the top level.
  localparam int DEF_GRID_SIZE     = 32;
  localparam int DEF_POINT_ID_BITS = 20;

  // Fixed field widths.
  localparam int POS_W   = 32;
  localparam int NORM_W  = 16;
  localparam int ID_W    = 20;
  localparam int ADDR_W  = 15;
  localparam int STEP_W  = 31;

  // Request kinds carried in tuser.
  localparam logic FUNC_SPLAT = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_STEP_X   = 3'd3;
  localparam logic [2:0] REG_STEP_Y   = 3'd4;
  localparam logic [2:0] REG_STEP_Z   = 3'd5;
  localparam logic [2:0] REG_MAX_SQ   = 3'd6;
  localparam logic [2:0] REG_REACH    = 3'd7;

  // Value of a sample that no point has written.
  localparam logic [31:0] UNSET_DIST = 32'h7FFF_FFFF;
  localparam logic [ID_W-1:0] UNSET_ID = '1;

  // Restoring divider runs one quotient bit per cycle over a 33-bit magnitude.
  localparam int DIV_STEPS = 33;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_CELL,
    ST_ADDR,
    ST_VEC,
    ST_MUL,
    ST_CMP,
    ST_RD,
    ST_RSP
  } state_t;

endpackage

### hw/rtl/sdf_point_splat_grid.sv
// Top level of the signed-distance point splatter: sequencer, shared divider,
// per-sample arithmetic and the sample store. Depends on sdfps_pkg.
//
// A splat request runs the per-axis floor division in the shared restoring
// divider (33 quotient bits, one per cycle, then a step to form the cell
// index), then visits each sample of the (reach+2)^3 window: a sample outside
// the grid takes only the address step, a sample inside it takes the address,
// three vector and three multiply steps, compare and write. The sequencer
// returns to idle before the next request is taken. A read request passes
// through the registered store read port. After reset the store is cleared
// one sample per cycle, all GRID_SIZE^3 samples (32768 at the default size),
// while no request is accepted; configuration writes are taken at all times.
// A read result waits in an output register.
module sdf_point_splat_grid
  import sdfps_pkg::*;
#(
  parameter int GRID_SIZE     = DEF_GRID_SIZE,
  parameter int POINT_ID_BITS = DEF_POINT_ID_BITS
) (
  input  logic         clk,
  input  logic         rst,
  // Configuration write channel.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  // Request channel.
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64], norm_x[111:96], norm_y[127:112],
  // norm_z[143:128], point_id[163:144], sample_addr[178:164], zero fill
  input  logic [183:0] s_tdata,
  // func[0]
  input  logic [0:0]   s_tuser,
  // Result channel.
  output logic         m_tvalid,
  input  logic         m_tready,
  // sdf_value[31:0], nearest_point[51:32], zero fill
  output logic [55:0]  m_tdata,
  // has_point[0]
  output logic [0:0]   m_tuser
);

  localparam int IDX_BITS   = $clog2(GRID_SIZE);
  localparam int CELL_COUNT = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int MEM_AW     = $clog2(CELL_COUNT);
  localparam int MEM_W      = 33 + POINT_ID_BITS;
  localparam int VW         = IDX_BITS + 34;
  localparam int DW         = VW + NORM_W + 2;

  // Configuration registers.
  logic signed [31:0] org [3];
  logic [STEP_W-1:0]  stp [3];
  logic [63:0]        max_sq;
  logic [2:0]         reach;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      org[0] <= '0;
      org[1] <= '0;
      org[2] <= '0;
      stp[0] <= STEP_W'(65536);
      stp[1] <= STEP_W'(65536);
      stp[2] <= STEP_W'(65536);
      max_sq <= 64'h1_0000_0000;
      reach  <= 3'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ORIGIN_X: org[0] <= cfg_data[31:0];
        REG_ORIGIN_Y: org[1] <= cfg_data[31:0];
        REG_ORIGIN_Z: org[2] <= cfg_data[31:0];
        REG_STEP_X:   stp[0] <= cfg_data[STEP_W-1:0];
        REG_STEP_Y:   stp[1] <= cfg_data[STEP_W-1:0];
        REG_STEP_Z:   stp[2] <= cfg_data[STEP_W-1:0];
        REG_MAX_SQ:   max_sq <= cfg_data;
        REG_REACH:    reach  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Effective step (zero acts as one) and clamped reach.
  logic [STEP_W-1:0] step_eff [3];
  logic [2:0]        r_eff;
  logic [2:0]        win_last;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      step_eff[k] = (stp[k] == '0) ? STEP_W'(1) : stp[k];
    end
    if (reach == 3'd0) begin
      r_eff = 3'd1;
    end else if (reach > 3'd4) begin
      r_eff = 3'd4;
    end else begin
      r_eff = reach;
    end
    win_last = r_eff + 3'd1;
  end

  // Request fields.
  logic               in_func;
  logic signed [31:0] in_pos [3];
  logic signed [15:0] in_norm [3];
  logic [ID_W-1:0]    in_id;
  logic [ADDR_W-1:0]  in_addr;

  assign in_func    = s_tuser[0];
  assign in_pos[0]  = s_tdata[31:0];
  assign in_pos[1]  = s_tdata[63:32];
  assign in_pos[2]  = s_tdata[95:64];
  assign in_norm[0] = s_tdata[111:96];
  assign in_norm[1] = s_tdata[127:112];
  assign in_norm[2] = s_tdata[143:128];
  assign in_id      = s_tdata[163:144];
  assign in_addr    = s_tdata[178:164];

  state_t state, state_next;

  logic                     accept;
  logic signed [31:0]       pos [3];
  logic signed [15:0]       norm [3];
  logic [POINT_ID_BITS-1:0] pid;
  logic [1:0]               ax;
  logic [5:0]               div_cnt;
  logic [32:0]              quo;
  logic [31:0]              rem;
  logic                     div_neg;
  logic signed [34:0]       cell_pos [3];
  logic [2:0]               cnt [3];
  logic [IDX_BITS-1:0]      idx [3];
  logic [MEM_AW-1:0]        lin;
  logic                     rd_oor;
  logic signed [VW-1:0]     vreg;
  logic [65:0]              sq_acc;
  logic signed [DW-1:0]     dot_acc;
  logic                     is_zero;
  logic                     is_far;
  logic [MEM_AW-1:0]        clr_cnt;

  // Store and its ports.
  logic [MEM_W-1:0]  mem [CELL_COUNT];
  logic [MEM_W-1:0]  rdata;
  logic              we;
  logic [MEM_AW-1:0] waddr;
  logic [MEM_W-1:0]  wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[lin];
  end

  // Divider operands for the axis being worked on.
  logic signed [32:0] div_num;
  logic [31:0]        div_sh;
  logic [32:0]        div_diff;

  always_comb begin
    div_num  = 33'(pos[ax]) - 33'(org[ax]);
    div_sh   = {rem[30:0], quo[32]};
    div_diff = {1'b0, div_sh} - {2'b00, step_eff[ax]};
  end

  // Floor quotient from magnitude, sign and remainder.
  logic [34:0] q_mag;
  logic [34:0] cell_val;

  always_comb begin
    q_mag    = {2'b00, quo} + 35'((rem != '0) && div_neg);
    cell_val = div_neg ? (35'd0 - q_mag) : q_mag;
  end

  // Sample index per axis and the grid bounds check.
  logic signed [35:0] idx_full [3];
  logic               in_grid;
  logic [MEM_AW-1:0]  lin_calc;

  always_comb begin
    in_grid = 1'b1;
    for (int k = 0; k < 3; k++) begin
      idx_full[k] = 36'(cell_pos[k]) + 36'(cnt[k]) - 36'(r_eff);
      if (idx_full[k] < 0 || idx_full[k] >= 36'(GRID_SIZE)) begin
        in_grid = 1'b0;
      end
    end
    lin_calc = MEM_AW'(idx_full[2][IDX_BITS-1:0]) * MEM_AW'(GRID_SIZE * GRID_SIZE)
             + MEM_AW'(idx_full[1][IDX_BITS-1:0]) * MEM_AW'(GRID_SIZE)
             + MEM_AW'(idx_full[0][IDX_BITS-1:0]);
  end

  // Window walk: x fastest, then y, then z.
  logic win_done;
  assign win_done = (cnt[0] == win_last) && (cnt[1] == win_last) && (cnt[2] == win_last);

  // Vector component: origin + index * step - position.
  logic [IDX_BITS+STEP_W-1:0] span;
  logic signed [VW-1:0]       v_calc;

  always_comb begin
    span   = idx[ax] * step_eff[ax];
    v_calc = VW'(org[ax]) + VW'($signed({1'b0, span})) - VW'(pos[ax]);
  end

  // Square and dot terms of the current component.
  logic [VW-1:0]          v_mag;
  logic [63:0]            v_sq;
  logic signed [DW-1:0]   v_dot;

  always_comb begin
    v_mag = vreg[VW-1] ? (VW'(0) - vreg) : vreg;
    v_sq  = v_mag[31:0] * v_mag[31:0];
    v_dot = DW'(vreg) * DW'(norm[ax]);
  end

  // Distance, saturation and the keep-closer test.
  localparam logic signed [DW-1:0] SAT_HI = DW'(64'sd2147483647);
  localparam logic signed [DW-1:0] SAT_LO = DW'(-64'sd2147483648);

  logic signed [DW-1:0] d_sh;
  logic [31:0]          d_sat;
  logic [32:0]          d_abs;
  logic [32:0]          s_abs;
  logic                 take;
  logic [POINT_ID_BITS+ID_W-1:0] id_in_ext;

  always_comb begin
    d_sh = dot_acc >>> 15;
    if (d_sh > SAT_HI) begin
      d_sat = 32'h7FFF_FFFF;
    end else if (d_sh < SAT_LO) begin
      d_sat = 32'h8000_0000;
    end else begin
      d_sat = d_sh[31:0];
    end
    d_abs = d_sat[31] ? (33'd0 - {1'b1, d_sat}) : {1'b0, d_sat};
    s_abs = rdata[31] ? (33'd0 - {1'b1, rdata[31:0]}) : {1'b0, rdata[31:0]};
    take  = !is_zero && !is_far && (sq_acc[65:64] == 2'b00) && (sq_acc[63:0] <= max_sq)
          && (d_abs < s_abs);
    id_in_ext = {{POINT_ID_BITS{1'b0}}, in_id};
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == MEM_AW'(CELL_COUNT - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (in_func == FUNC_READ) ? ST_RD : ST_DIV;
        end
      end
      ST_DIV:  if (div_cnt == 6'(DIV_STEPS - 1)) state_next = ST_CELL;
      ST_CELL: state_next = (ax == 2'd2) ? ST_ADDR : ST_DIV;
      ST_ADDR: begin
        if (in_grid) begin
          state_next = ST_VEC;
        end else if (win_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_VEC:  state_next = ST_MUL;
      ST_MUL:  state_next = (ax == 2'd2) ? ST_CMP : ST_VEC;
      ST_CMP:  state_next = win_done ? ST_IDLE : ST_ADDR;
      ST_RD:   state_next = ST_RSP;
      ST_RSP:  if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake and store write controls.
  always_comb begin
    s_tready = (state == ST_IDLE);
    we       = 1'b0;
    waddr    = lin;
    wdata    = {1'b1, id_in_ext[POINT_ID_BITS+ID_W-1:ID_W], d_sat};
    wdata[MEM_W-2:32] = pid;
    unique case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt;
        wdata = {1'b0, {POINT_ID_BITS{1'b1}}, UNSET_DIST};
      end
      ST_CMP:  we = take;
      default: ;
    endcase
  end

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + MEM_AW'(1);
      end
    end
  end

  // Datapath registers.
  logic [MEM_AW+ADDR_W-1:0] rd_addr_ext;
  assign rd_addr_ext = {{MEM_AW{1'b0}}, in_addr};

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          pos  <= in_pos;
          norm <= in_norm;
          pid  <= id_in_ext[POINT_ID_BITS-1:0];
          ax   <= 2'd0;
          div_cnt <= '0;
          // Axis zero operands come straight from the request.
          div_neg <= (33'(in_pos[0]) - 33'(org[0])) < 0;
          quo     <= ((33'(in_pos[0]) - 33'(org[0])) < 0)
                   ? (33'd0 - (33'(in_pos[0]) - 33'(org[0])))
                   : (33'(in_pos[0]) - 33'(org[0]));
          rem     <= '0;
          lin     <= rd_addr_ext[MEM_AW-1:0];
          rd_oor  <= {17'd0, in_addr} >= 32'(CELL_COUNT);
        end
      end
      ST_DIV: begin
        div_cnt <= div_cnt + 6'd1;
        if (!div_diff[32]) begin
          rem <= div_diff[31:0];
          quo <= {quo[31:0], 1'b1};
        end else begin
          rem <= div_sh;
          quo <= {quo[31:0], 1'b0};
        end
      end
      ST_CELL: begin
        cell_pos[ax] <= cell_val;
        if (ax != 2'd2) begin
          ax <= ax + 2'd1;
        end
        cnt[0] <= '0;
        cnt[1] <= '0;
        cnt[2] <= '0;
        div_cnt <= '0;
        rem     <= '0;
      end
      ST_ADDR: begin
        ax      <= 2'd0;
        sq_acc  <= '0;
        dot_acc <= '0;
        is_zero <= 1'b1;
        is_far  <= 1'b0;
        lin     <= lin_calc;
        for (int k = 0; k < 3; k++) begin
          idx[k] <= idx_full[k][IDX_BITS-1:0];
        end
        if (!in_grid) begin
          if (cnt[0] != win_last) begin
            cnt[0] <= cnt[0] + 3'd1;
          end else begin
            cnt[0] <= '0;
            if (cnt[1] != win_last) begin
              cnt[1] <= cnt[1] + 3'd1;
            end else begin
              cnt[1] <= '0;
              cnt[2] <= cnt[2] + 3'd1;
            end
          end
        end
      end
      ST_VEC: vreg <= v_calc;
      ST_MUL: begin
        if (vreg != '0) begin
          is_zero <= 1'b0;
        end
        if (v_mag[VW-1:32] != '0) begin
          is_far <= 1'b1;
        end else begin
          sq_acc <= sq_acc + 66'(v_sq);
        end
        dot_acc <= dot_acc + v_dot;
        if (ax != 2'd2) begin
          ax <= ax + 2'd1;
        end
      end
      ST_CMP: begin
        if (cnt[0] != win_last) begin
          cnt[0] <= cnt[0] + 3'd1;
        end else begin
          cnt[0] <= '0;
          if (cnt[1] != win_last) begin
            cnt[1] <= cnt[1] + 3'd1;
          end else begin
            cnt[1] <= '0;
            cnt[2] <= cnt[2] + 3'd1;
          end
        end
      end
      default: ;
    endcase
    // Load the next axis into the divider as the previous one finishes.
    if (state == ST_CELL && ax != 2'd2) begin
      div_neg <= (33'(pos[ax + 2'd1]) - 33'(org[ax + 2'd1])) < 0;
      quo     <= ((33'(pos[ax + 2'd1]) - 33'(org[ax + 2'd1])) < 0)
               ? (33'd0 - (33'(pos[ax + 2'd1]) - 33'(org[ax + 2'd1])))
               : (33'(pos[ax + 2'd1]) - 33'(org[ax + 2'd1]));
    end
  end

  // Output register for read results.
  logic [POINT_ID_BITS+ID_W-1:0] id_out_ext;
  assign id_out_ext = {{ID_W{1'b0}}, rdata[MEM_W-2:32]};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_RSP && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (state == ST_RSP && (!m_tvalid || m_tready)) begin
      if (rd_oor || !rdata[MEM_W-1]) begin
        // An address beyond the grid reads as an unset sample.
        m_tdata    <= {4'd0, UNSET_ID, (rd_oor ? UNSET_DIST : rdata[31:0])};
        m_tuser[0] <= 1'b0;
      end else begin
        m_tdata    <= {4'd0, id_out_ext[ID_W-1:0], rdata[31:0]};
        m_tuser[0] <= 1'b1;
      end
    end
  end

`ifndef SYNTH
  // No request is taken while the store is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !s_tready)
    else $error("request accepted during store clear");

  // The multiply step always follows a vector step.
  a_mul_after_vec: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> ($past(state) == ST_VEC))
    else $error("multiply step without vector step");

  // A sample update only happens after the compare step saw a passing test.
  a_write_on_take: assert property (@(posedge clk) disable iff (rst)
    (we && state != ST_CLEAR) |-> (state == ST_CMP && take))
    else $error("store written outside compare step");
`endif

endmodule
